// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk_, rst_n_, expr_) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (expr_)) \
		else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk_, rst_n_, ante_, cons_) \
	lbl: assert property (@(posedge clk_) disable iff (!rst_n_) (ante_) |=> (cons_)) \
		else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk_, rst_n_, expr_)

`define ASSERT_NEXT(lbl, clk_, rst_n_, ante_, cons_)

`endif

`endif

// File: rtl/hbp_pkg.sv
// ----------------------------------------------------------------------------
// hbp_pkg
// Types, sizes and counter helpers of the hybrid branch predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbp_pkg;

	localparam int BIM_IDX_BITS = 12;
	localparam int GSH_IDX_BITS = 12;
	localparam int HIST_BITS    = 8;
	localparam int CHO_IDX_BITS = 10;

	localparam int BG_MAX_BITS = (BIM_IDX_BITS > GSH_IDX_BITS) ? BIM_IDX_BITS : GSH_IDX_BITS;
	localparam int CLR_BITS    = (BG_MAX_BITS > CHO_IDX_BITS) ? BG_MAX_BITS : CHO_IDX_BITS;

	typedef logic [1:0] ctr_t;

	localparam ctr_t CTR_MIN        = 2'd0;
	localparam ctr_t CTR_MAX        = 2'd3;
	localparam ctr_t CTR_WEAK_TAKEN = 2'd2;
	localparam ctr_t CTR_WEAK_BIM   = 2'd1;

	typedef struct packed {
		logic [31:0] branch_address;
		logic        branch_taken;
	} branch_item_t;

	typedef struct packed {
		logic        predicted_taken;
		logic        used_gshare;
		logic        mispredicted;
		logic [31:0] prediction_count;
		logic [31:0] misprediction_count;
	} result_item_t;

	function automatic ctr_t sat_move(input ctr_t c, input logic up);
		if (up) begin
			return (c == CTR_MAX) ? c : c + 2'd1;
		end
		return (c == CTR_MIN) ? c : c - 2'd1;
	endfunction

	// place history at the top of the index, then fold in address bits
	function automatic logic [GSH_IDX_BITS-1:0] gsh_index(
		input logic [31:0]          addr,
		input logic [HIST_BITS-1:0] hist
	);
		logic [GSH_IDX_BITS+HIST_BITS-1:0] wide;
		wide = {hist, {GSH_IDX_BITS{1'b0}}};
		return addr[GSH_IDX_BITS+1:2] ^ wide[GSH_IDX_BITS+HIST_BITS-1 -: GSH_IDX_BITS];
	endfunction

	// shift right, outcome enters at the top
	function automatic logic [HIST_BITS-1:0] hist_push(
		input logic [HIST_BITS-1:0] hist,
		input logic                 taken
	);
		return (hist >> 1) | (HIST_BITS'(taken) << (HIST_BITS - 1));
	endfunction

endpackage

// File: rtl/hbp_ctr_ram.sv
// ----------------------------------------------------------------------------
// hbp_ctr_ram
// Counter table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbp_ctr_ram
	import hbp_pkg::*;
#(
	parameter int ADDR_BITS = 12
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic [ADDR_BITS-1:0] wr_addr,
	input  ctr_t                 wr_data,
	input  logic                 rd_en,
	input  logic [ADDR_BITS-1:0] rd_addr,
	output ctr_t                 rd_data
);

	ctr_t mem [2**ADDR_BITS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/hybrid_branch_predictor.sv
// A branch's result is registered as it leaves stage 1. Throughput: one branch per
// cycle while results are taken; each table does one read and one write per cycle,
// with the newest write forwarded over the registered read.
// Reset: history and totals clear at once; a clearing pass over all 2**CLR_BITS (4096)
// addresses then writes the reset counter values; branch_ready stays low until it ends.
// ----------------------------------------------------------------------------
// hybrid_branch_predictor
// Tournament predictor: bimodal and gshare tables with a per-address chooser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hybrid_branch_predictor
	import hbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         branch_valid,
	output logic         branch_ready,
	input  branch_item_t branch,
	output logic         result_valid,
	input  logic         result_ready,
	output result_item_t result
);

	logic                    clr_done_q;
	logic [CLR_BITS-1:0]     clr_q;

	logic                    valid_s1;
	logic                    taken_s1;
	logic [BIM_IDX_BITS-1:0] bim_idx_s1;
	logic [GSH_IDX_BITS-1:0] gsh_idx_s1;
	logic [CHO_IDX_BITS-1:0] cho_idx_s1;

	logic [HIST_BITS-1:0]    hist_q;
	logic [31:0]             total_q;
	logic [31:0]             miss_total_q;

	logic                    bim_lw_vld_q;
	logic [BIM_IDX_BITS-1:0] bim_lw_addr_q;
	ctr_t                    bim_lw_data_q;
	logic                    gsh_lw_vld_q;
	logic [GSH_IDX_BITS-1:0] gsh_lw_addr_q;
	ctr_t                    gsh_lw_data_q;
	logic                    cho_lw_vld_q;
	logic [CHO_IDX_BITS-1:0] cho_lw_addr_q;
	ctr_t                    cho_lw_data_q;

	logic                    res_vld_q;
	result_item_t            res_q;

	ctr_t                    bim_rd;
	ctr_t                    gsh_rd;
	ctr_t                    cho_rd;
	ctr_t                    bim_ctr;
	ctr_t                    gsh_ctr;
	ctr_t                    cho_ctr;

	logic                    adv_s1;
	logic                    in_fire;
	logic [HIST_BITS-1:0]    hist_eff;
	logic [BIM_IDX_BITS-1:0] bim_rd_addr;
	logic [GSH_IDX_BITS-1:0] gsh_rd_addr;
	logic [CHO_IDX_BITS-1:0] cho_rd_addr;

	logic                    bim_pred;
	logic                    gsh_pred;
	logic                    use_gsh;
	logic                    pred;
	logic                    miss;
	logic                    cho_up;
	logic                    cho_dn;

	logic                    bim_upd;
	logic                    gsh_upd;
	logic                    cho_upd;
	ctr_t                    bim_new;
	ctr_t                    gsh_new;
	ctr_t                    cho_new;

	logic                    bim_we;
	logic [BIM_IDX_BITS-1:0] bim_wa;
	ctr_t                    bim_wd;
	logic                    gsh_we;
	logic [GSH_IDX_BITS-1:0] gsh_wa;
	ctr_t                    gsh_wd;
	logic                    cho_we;
	logic [CHO_IDX_BITS-1:0] cho_wa;
	ctr_t                    cho_wd;

	logic [31:0]             total_nx;
	logic [31:0]             miss_total_nx;

	assign adv_s1       = valid_s1 && (!res_vld_q || result_ready);
	assign branch_ready = clr_done_q && (!valid_s1 || adv_s1);
	assign in_fire      = branch_valid && branch_ready;

	// the branch in stage 1 retires at the same edge, so its outcome is in the history
	assign hist_eff    = adv_s1 ? hist_push(hist_q, taken_s1) : hist_q;
	assign bim_rd_addr = branch.branch_address[BIM_IDX_BITS+1:2];
	assign gsh_rd_addr = gsh_index(branch.branch_address, hist_eff);
	assign cho_rd_addr = branch.branch_address[CHO_IDX_BITS+1:2];

	// the last write always matches the table contents at its address
	assign bim_ctr = (bim_lw_vld_q && bim_lw_addr_q == bim_idx_s1) ? bim_lw_data_q : bim_rd;
	assign gsh_ctr = (gsh_lw_vld_q && gsh_lw_addr_q == gsh_idx_s1) ? gsh_lw_data_q : gsh_rd;
	assign cho_ctr = (cho_lw_vld_q && cho_lw_addr_q == cho_idx_s1) ? cho_lw_data_q : cho_rd;

	assign bim_pred = bim_ctr[1];
	assign gsh_pred = gsh_ctr[1];
	assign use_gsh  = cho_ctr[1];
	assign pred     = use_gsh ? gsh_pred : bim_pred;
	assign miss     = pred != taken_s1;
	assign cho_up   = (gsh_pred == taken_s1) && (bim_pred != taken_s1);
	assign cho_dn   = (gsh_pred != taken_s1) && (bim_pred == taken_s1);

	assign bim_upd = adv_s1 && !use_gsh;
	assign gsh_upd = adv_s1 && use_gsh;
	assign cho_upd = adv_s1 && (cho_up || cho_dn);
	assign bim_new = sat_move(bim_ctr, taken_s1);
	assign gsh_new = sat_move(gsh_ctr, taken_s1);
	assign cho_new = sat_move(cho_ctr, cho_up);

	assign total_nx      = total_q + 32'd1;
	assign miss_total_nx = miss_total_q + 32'(miss);

	always_comb begin
		if (!clr_done_q) begin
			bim_we = 1'b1;
			bim_wa = clr_q[BIM_IDX_BITS-1:0];
			bim_wd = CTR_WEAK_TAKEN;
			gsh_we = 1'b1;
			gsh_wa = clr_q[GSH_IDX_BITS-1:0];
			gsh_wd = CTR_WEAK_TAKEN;
			cho_we = 1'b1;
			cho_wa = clr_q[CHO_IDX_BITS-1:0];
			cho_wd = CTR_WEAK_BIM;
		end else begin
			bim_we = bim_upd;
			bim_wa = bim_idx_s1;
			bim_wd = bim_new;
			gsh_we = gsh_upd;
			gsh_wa = gsh_idx_s1;
			gsh_wd = gsh_new;
			cho_we = cho_upd;
			cho_wa = cho_idx_s1;
			cho_wd = cho_new;
		end
	end

	hbp_ctr_ram #(.ADDR_BITS(BIM_IDX_BITS)) u_bim_ram (
		.clk     (clk),
		.wr_en   (bim_we),
		.wr_addr (bim_wa),
		.wr_data (bim_wd),
		.rd_en   (in_fire),
		.rd_addr (bim_rd_addr),
		.rd_data (bim_rd)
	);

	hbp_ctr_ram #(.ADDR_BITS(GSH_IDX_BITS)) u_gsh_ram (
		.clk     (clk),
		.wr_en   (gsh_we),
		.wr_addr (gsh_wa),
		.wr_data (gsh_wd),
		.rd_en   (in_fire),
		.rd_addr (gsh_rd_addr),
		.rd_data (gsh_rd)
	);

	hbp_ctr_ram #(.ADDR_BITS(CHO_IDX_BITS)) u_cho_ram (
		.clk     (clk),
		.wr_en   (cho_we),
		.wr_addr (cho_wa),
		.wr_data (cho_wd),
		.rd_en   (in_fire),
		.rd_addr (cho_rd_addr),
		.rd_data (cho_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q        <= '0;
			clr_done_q   <= 1'b0;
			valid_s1     <= 1'b0;
			res_vld_q    <= 1'b0;
			hist_q       <= '0;
			total_q      <= '0;
			miss_total_q <= '0;
			bim_lw_vld_q <= 1'b0;
			gsh_lw_vld_q <= 1'b0;
			cho_lw_vld_q <= 1'b0;
		end else begin
			if (!clr_done_q) begin
				clr_q <= clr_q + 1'b1;
				if (&clr_q) begin
					clr_done_q <= 1'b1;
				end
			end
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				res_vld_q    <= 1'b1;
				hist_q       <= hist_push(hist_q, taken_s1);
				total_q      <= total_nx;
				miss_total_q <= miss_total_nx;
			end else if (result_ready) begin
				res_vld_q <= 1'b0;
			end
			if (bim_upd) begin
				bim_lw_vld_q <= 1'b1;
			end
			if (gsh_upd) begin
				gsh_lw_vld_q <= 1'b1;
			end
			if (cho_upd) begin
				cho_lw_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			taken_s1   <= branch.branch_taken;
			bim_idx_s1 <= bim_rd_addr;
			gsh_idx_s1 <= gsh_rd_addr;
			cho_idx_s1 <= cho_rd_addr;
		end
		if (bim_upd) begin
			bim_lw_addr_q <= bim_idx_s1;
			bim_lw_data_q <= bim_new;
		end
		if (gsh_upd) begin
			gsh_lw_addr_q <= gsh_idx_s1;
			gsh_lw_data_q <= gsh_new;
		end
		if (cho_upd) begin
			cho_lw_addr_q <= cho_idx_s1;
			cho_lw_data_q <= cho_new;
		end
		if (adv_s1) begin
			res_q.predicted_taken     <= pred;
			res_q.used_gshare         <= use_gsh;
			res_q.mispredicted        <= miss;
			res_q.prediction_count    <= total_nx;
			res_q.misprediction_count <= miss_total_nx;
		end
	end

	assign result_valid = res_vld_q;
	assign result       = res_q;

	`ASSERT_ALWAYS(a_no_accept_in_clear, clk, arst_n, !branch_ready || clr_done_q)
	`ASSERT_ALWAYS(a_one_table_trained, clk, arst_n, !(bim_upd && gsh_upd))
	`ASSERT_NEXT(a_total_step, clk, arst_n, adv_s1, total_q == $past(total_q) + 32'd1)
	`ASSERT_NEXT(a_miss_hold, clk, arst_n, adv_s1 && !miss, miss_total_q == $past(miss_total_q))
	`ASSERT_NEXT(a_retire_shows, clk, arst_n, adv_s1, result_valid)

endmodule
